// ===== src/rar_pkg.sv =====
`default_nettype none
package rar_pkg;
  localparam int DefWidth = 32;

  localparam logic [1:0] CMD_ADD = 2'd0;
  localparam logic [1:0] CMD_SUB = 2'd1;
  localparam logic [1:0] CMD_MUL = 2'd2;
  localparam logic [1:0] CMD_DIV = 2'd3;

  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_NAN = 2'd1;
  localparam logic [1:0] ST_OVF = 2'd2;

  typedef struct packed {
    logic load;      // capture operands, start products
    logic mul_step;  // run one product step
    logic gcd_init;  // load gcd working regs
    logic gcd_step;  // one remainder bit step
    logic div_init;  // start exact divides
    logic div_step;  // one quotient bit step
    logic finish;    // form result word
  } rar_cmd_t;

  typedef struct packed {
    logic mul_done;
    logic gcd_done;
    logic div_done;
  } rar_stat_t;
endpackage
`default_nettype wire

// ===== src/rar_if.sv =====
`default_nettype none
interface rar_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [31:0] a_num;
  logic [31:0] a_den;
  logic [31:0] b_num;
  logic [31:0] b_den;
  modport source (output valid, cmd, a_num, a_den, b_num, b_den, input ready);
  modport sink (input valid, cmd, a_num, a_den, b_num, b_den, output ready);
endinterface

interface rar_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] res_num;
  logic [30:0] res_den;
  logic [1:0]  status;
  modport source (output valid, res_num, res_den, status, input ready);
  modport sink (input valid, res_num, res_den, status, output ready);
endinterface
`default_nettype wire

// ===== src/rar_ctrl.sv =====
`default_nettype none
module rar_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output rar_pkg::rar_cmd_t      cmd,
  input  wire rar_pkg::rar_stat_t stat
);
  import rar_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_MUL  = 7'b0000010,
    S_GINI = 7'b0000100,
    S_GCD  = 7'b0001000,
    S_DINI = 7'b0010000,
    S_DIV  = 7'b0100000,
    S_OUT  = 7'b1000000
  } state_t;

  state_t state, state_next;

  // the output register holds one result; a new item may start while it waits
  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd = '0;
    case (state)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          cmd.load = 1'b1;
          state_next = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul_step = 1'b1;
        if (stat.mul_done) state_next = S_GINI;
      end
      S_GINI: begin
        cmd.gcd_init = 1'b1;
        state_next = S_GCD;
      end
      S_GCD: begin
        cmd.gcd_step = 1'b1;
        if (stat.gcd_done) state_next = S_DINI;
      end
      S_DINI: begin
        cmd.div_init = 1'b1;
        state_next = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_done) state_next = S_OUT;
      end
      S_OUT: begin
        if (!out_valid || out_ready) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.finish) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  a_onehot: assert property (@(posedge clk) disable iff (rst) $onehot(state))
    else $error("state not one-hot");
  a_load_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> (state == S_IDLE))
    else $error("load outside idle");
  a_fin_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> out_valid)
    else $error("result not shown");
endmodule
`default_nettype wire

// ===== src/rar_dp.sv =====
`default_nettype none
module rar_dp #(
  parameter int WIDTH = rar_pkg::DefWidth
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic [1:0]         op,
  input  wire logic [31:0]        a_num,
  input  wire logic [31:0]        a_den,
  input  wire logic [31:0]        b_num,
  input  wire logic [31:0]        b_den,
  input  wire rar_pkg::rar_cmd_t  cmd,
  output rar_pkg::rar_stat_t      stat,
  output logic [31:0]             res_num,
  output logic [30:0]             res_den,
  output logic [1:0]              status
);
  import rar_pkg::*;

  localparam int MW = WIDTH + 1;          // operand magnitude bits (can be 2^(WIDTH-1))
  localparam int PW = 2 * WIDTH + 2;      // product / sum magnitude bits
  localparam int CW = $clog2(PW + 1);
  localparam logic [MW-1:0] WMASK = {1'b0, {WIDTH{1'b1}}};

  // sign-magnitude of an operand from its low WIDTH bits
  function automatic logic [MW:0] to_sm(input logic [31:0] raw);
    logic [MW-1:0] v;
    logic          n;
    logic [MW-1:0] m;
    begin
      v = {{(MW-WIDTH){1'b0}}, raw[WIDTH-1:0]};
      n = raw[WIDTH-1];
      m = n ? ((~v + 1'b1) & WMASK) : v;
      if (n && m == '0) m = {1'b1, {WIDTH{1'b0}}};
      to_sm = {n, m};
    end
  endfunction

  // three shift-add products share the step counter
  logic [MW-1:0] m1a, m1b, m2a, m2b, m3a, m3b;
  logic          s1, s2, s3;
  logic [PW-1:0] p1, p2, p3;
  logic [CW-1:0] cnt;

  // gcd / divider regs
  logic [PW-1:0] nmag, dmag, gx, gy, rem, quo_n, quo_d, rn, rd;
  logic          nneg, dneg;

  logic [MW:0] san, sad, sbn, sbd;
  always_comb begin
    san = to_sm(a_num);
    sad = to_sm(a_den);
    sbn = to_sm(b_num);
    sbd = to_sm(b_den);
  end

  logic [PW-1:0] rem_sh, rn_sh, rd_sh;
  logic          g_last;

  assign stat.mul_done = (cnt == CW'(MW - 1));
  assign stat.div_done = (cnt == CW'(PW - 1));
  assign g_last        = (cnt == CW'(PW - 1));
  assign stat.gcd_done = (gy == '0);

  assign rem_sh = {rem[PW-2:0], gx[PW-1-cnt[CW-1:0]]};

  // sum of signed products and final magnitudes
  logic [PW-1:0] sum_mag;
  logic          sum_neg;
  always_comb begin
    if (s1 == s2) begin
      sum_mag = p1 + p2;
      sum_neg = s1;
    end else if (p1 >= p2) begin
      sum_mag = p1 - p2;
      sum_neg = s1;
    end else begin
      sum_mag = p2 - p1;
      sum_neg = s2;
    end
    if (sum_mag == '0) sum_neg = 1'b0;
  end

  logic [PW-1:0] lim;
  assign lim = {{(PW-WIDTH){1'b0}}, 1'b1, {(WIDTH-1){1'b0}}};
  logic neg_res, ovf;
  assign neg_res = nneg ^ dneg;
  assign ovf = (quo_d > lim - 1'b1) || (neg_res ? (quo_n > lim) : (quo_n > lim - 1'b1));
  logic [WIDTH-1:0] nfit;
  assign nfit = neg_res ? (~quo_n[WIDTH-1:0] + 1'b1) : quo_n[WIDTH-1:0];

  logic [PW-1:0] trial_n, trial_d;
  assign rn_sh = {rn[PW-2:0], quo_n[PW-1]};
  assign rd_sh = {rd[PW-2:0], quo_d[PW-1]};
  assign trial_n = rn_sh - gx;
  assign trial_d = rd_sh - gx;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (cmd.load) begin
      cnt <= '0;
      p1 <= '0; p2 <= '0; p3 <= '0;
      case (op)
        CMD_ADD, CMD_SUB: begin
          m1a <= san[MW-1:0]; m1b <= sbd[MW-1:0]; s1 <= san[MW] ^ sbd[MW];
          m2a <= sbn[MW-1:0]; m2b <= sad[MW-1:0];
          s2 <= (sbn[MW] ^ (op == CMD_SUB)) ^ sad[MW];
          m3a <= sad[MW-1:0]; m3b <= sbd[MW-1:0]; s3 <= sad[MW] ^ sbd[MW];
        end
        CMD_MUL: begin
          m1a <= san[MW-1:0]; m1b <= sbn[MW-1:0]; s1 <= san[MW] ^ sbn[MW];
          m2a <= '0; m2b <= '0; s2 <= 1'b0;
          m3a <= sad[MW-1:0]; m3b <= sbd[MW-1:0]; s3 <= sad[MW] ^ sbd[MW];
        end
        default: begin
          m1a <= san[MW-1:0]; m1b <= sbd[MW-1:0]; s1 <= san[MW] ^ sbd[MW];
          m2a <= '0; m2b <= '0; s2 <= 1'b0;
          m3a <= sad[MW-1:0]; m3b <= sbn[MW-1:0]; s3 <= sad[MW] ^ sbn[MW];
        end
      endcase
    end else if (cmd.mul_step) begin
      // msb-first shift-add, one multiplier bit per cycle
      p1 <= (p1 << 1) + (m1b[MW-1-cnt] ? PW'(m1a) : '0);
      p2 <= (p2 << 1) + (m2b[MW-1-cnt] ? PW'(m2a) : '0);
      p3 <= (p3 << 1) + (m3b[MW-1-cnt] ? PW'(m3a) : '0);
      cnt <= stat.mul_done ? '0 : cnt + 1'b1;
    end else if (cmd.gcd_init) begin
      nmag <= sum_mag;
      nneg <= sum_neg;
      dmag <= p3;
      dneg <= s3 && (p3 != '0);
      gx <= sum_mag;
      gy <= p3;
      rem <= '0;
      cnt <= '0;
    end else if (cmd.gcd_step) begin
      if (gy != '0) begin
        // restoring remainder: one dividend bit per cycle, swap at the end
        if (rem_sh >= gy) rem <= rem_sh - gy;
        else rem <= rem_sh;
        if (g_last) begin
          gx <= gy;
          gy <= (rem_sh >= gy) ? rem_sh - gy : rem_sh;
          rem <= '0;
          cnt <= '0;
        end else begin
          cnt <= cnt + 1'b1;
        end
      end
    end else if (cmd.div_init) begin
      quo_n <= nmag;
      quo_d <= dmag;
      rn <= '0;
      rd <= '0;
      cnt <= '0;
    end else if (cmd.div_step) begin
      // both exact quotients by the gcd in gx, one bit per cycle
      if (gx != '0) begin
        rn <= trial_n[PW-1] ? rn_sh : trial_n;
        rd <= trial_d[PW-1] ? rd_sh : trial_d;
        quo_n <= {quo_n[PW-2:0], ~trial_n[PW-1]};
        quo_d <= {quo_d[PW-2:0], ~trial_d[PW-1]};
      end
      cnt <= cnt + 1'b1;
    end
    if (cmd.finish) begin
      if (dmag == '0) begin
        res_num <= '0; res_den <= '0; status <= ST_NAN;
      end else if (nmag == '0) begin
        res_num <= '0; res_den <= 31'd1; status <= ST_OK;
      end else if (ovf) begin
        res_num <= '0; res_den <= '0; status <= ST_OVF;
      end else begin
        res_num <= 32'($signed(nfit));
        res_den <= 31'(quo_d);
        status <= ST_OK;
      end
    end
  end

  a_div_cnt: assert property (@(posedge clk) disable iff (rst)
    cmd.div_init |=> (cnt == '0))
    else $error("divide counter not cleared");
  a_gcd_init: assert property (@(posedge clk) disable iff (rst)
    cmd.gcd_init |=> (gy == dmag))
    else $error("gcd divisor not loaded");
  a_status: assert property (@(posedge clk) disable iff (rst)
    $past(cmd.finish) |-> (status == ST_OK || status == ST_NAN || status == ST_OVF))
    else $error("bad status code");
endmodule
`default_nettype wire

// ===== src/rational_arith_reduce.sv =====
// each item runs the product steps, then a bit-serial remainder per Euclid step,
//   then the exact divides and the result transfer
// throughput: one item at a time, set by the bit-serial remainder unit in the gcd loop
// the output register lets the next item start while a result waits for transfer
// reset: rst synchronous, active high, clears controller state and output valid
`default_nettype none
module rational_arith_reduce #(
  parameter int WIDTH = rar_pkg::DefWidth
) (
  input wire logic   clk,
  input wire logic   rst,
  rar_in_if.sink     in_ch,
  rar_out_if.source  out_ch
);
  import rar_pkg::*;

  rar_cmd_t  cmd;   // controller commands to datapath
  rar_stat_t stat;  // datapath loop status

  // sequencer: products, euclid loop, exact divides, result transfer
  rar_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  // datapath: shift-add products, bit-serial remainder unit, result register
  rar_dp #(.WIDTH(WIDTH)) u_dp (
    .clk     (clk),
    .rst     (rst),
    .op      (in_ch.cmd),
    .a_num   (in_ch.a_num),
    .a_den   (in_ch.a_den),
    .b_num   (in_ch.b_num),
    .b_den   (in_ch.b_den),
    .cmd     (cmd),
    .stat    (stat),
    .res_num (out_ch.res_num),
    .res_den (out_ch.res_den),
    .status  (out_ch.status)
  );
endmodule
`default_nettype wire

// ===== sim/rational_arith_reduce_tb.sv =====
module rational_arith_reduce_tb;
  import rar_pkg::*;

  typedef struct packed {
    logic [31:0] num;
    logic [30:0] den;
    logic [1:0]  status;
  } fraction_result_t;

  logic clk;
  logic rst;

  rar_in_if  in_ch ();
  rar_out_if out_ch ();

  rational_arith_reduce i_dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  // expected reduced fractions, oldest first
  fraction_result_t expected_fractions[$];
  int mismatch_count = 0;
  int sender_idle_pct;
  int receiver_idle_pct;
  logic hold_off_active;
  event hold_off_go;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // long fixed bound: the worst-case gcd loop runs long per item
  initial begin
    #400000000;
    $display("simulation failed");
    $finish;
  end

  // the operand is read as signed; -2^31 has magnitude 2^31
  function automatic logic [63:0] magnitude_of(input logic [31:0] v);
    if (v[31]) begin
      return {32'd0, ~v + 32'd1} | (v == 32'h8000_0000 ? 64'h8000_0000 : 64'd0);
    end
    return {32'd0, v};
  endfunction

  function automatic fraction_result_t reduce_fraction(input logic [1:0] op,
      input logic [31:0] an, input logic [31:0] ad,
      input logic [31:0] bn, input logic [31:0] bd);
    logic [63:0] anm, adm, bnm, bdm, p, q, nm, dm, x, y, t;
    logic pneg, qneg, nneg, dneg, bsign, neg;
    fraction_result_t r;
    anm = magnitude_of(an);
    adm = magnitude_of(ad);
    bnm = magnitude_of(bn);
    bdm = magnitude_of(bd);
    bsign = bn[31];
    if (op == CMD_SUB) bsign = (bnm != 0) && !bn[31];
    r = '0;
    case (op)
      CMD_ADD, CMD_SUB: begin
        p = anm * bdm;
        pneg = (p != 0) && (an[31] != bd[31]);
        q = bnm * adm;
        qneg = (q != 0) && (bsign != ad[31]);
        if (pneg == qneg) begin
          nm = p + q;
          nneg = pneg;
        end else if (p >= q) begin
          nm = p - q;
          nneg = pneg;
        end else begin
          nm = q - p;
          nneg = qneg;
        end
        dm = adm * bdm;
        dneg = ad[31] != bd[31];
      end
      CMD_MUL: begin
        nm = anm * bnm;
        nneg = an[31] != bn[31];
        dm = adm * bdm;
        dneg = ad[31] != bd[31];
      end
      default: begin
        nm = anm * bdm;
        nneg = an[31] != bd[31];
        dm = adm * bnm;
        dneg = ad[31] != bn[31];
      end
    endcase
    if (dm == 0) begin
      r.status = ST_NAN;
      return r;
    end
    if (nm == 0) begin
      r.den = 31'd1;
      r.status = ST_OK;
      return r;
    end
    x = nm;
    y = dm;
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
    end
    nm = nm / x;
    dm = dm / x;
    neg = nneg != dneg;
    if (dm > 64'h7FFF_FFFF || nm > (neg ? 64'h8000_0000 : 64'h7FFF_FFFF)) begin
      r.status = ST_OVF;
      return r;
    end
    r.num = neg ? (~nm[31:0] + 32'd1) : nm[31:0];
    r.den = dm[30:0];
    r.status = ST_OK;
    return r;
  endfunction

  // one transfer on the input side, with random idle before it
  task automatic send_fraction_op(input logic [1:0] op, input logic [31:0] an,
      input logic [31:0] ad, input logic [31:0] bn, input logic [31:0] bd);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.cmd   <= op;
    in_ch.a_num <= an;
    in_ch.a_den <= ad;
    in_ch.b_num <= bn;
    in_ch.b_den <= bd;
    expected_fractions.push_back(reduce_fraction(op, an, ad, bn, bd));
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // long receiver hold-off, counted here in cycles
  initial begin
    hold_off_active = 1'b0;
    @(hold_off_go);
    hold_off_active <= 1'b1;
    repeat (20000) @(posedge clk);
    hold_off_active <= 1'b0;
  end

  // receiver ready, with random stall or a long hold-off
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else if (hold_off_active) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= receiver_idle_pct);
    end
  end

  // result checker
  always @(posedge clk) begin
    fraction_result_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (expected_fractions.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("unexpected result %0d/%0d",
          $signed(out_ch.res_num), out_ch.res_den);
      end else begin
        want = expected_fractions.pop_front();
        if (out_ch.res_num !== want.num || out_ch.res_den !== want.den ||
            out_ch.status !== want.status) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch: expected %0d/%0d st %0d, got %0d/%0d st %0d",
              $signed(want.num), want.den, want.status,
              $signed(out_ch.res_num), out_ch.res_den, out_ch.status);
        end
      end
    end
  end

  function automatic logic [31:0] random_operand();
    case ($urandom_range(5))
      0: return $urandom_range(16) - 8;
      1: return $urandom_range(1000) - 500;
      2: return {$urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF} ^ $urandom_range(3);
      3: return $urandom >> $urandom_range(31);
      default: return $urandom;
    endcase
  endfunction

  task automatic test_directed();
    logic [1:0] op;
    for (int k = 0; k < 4; k++) begin
      op = k[1:0];
      send_fraction_op(op, 32'h7FFF_FFFF, 32'd1, 32'h8000_0000, 32'hFFFF_FFFF);
      send_fraction_op(op, 32'd0, 32'd5, 32'd0, 32'd7);   // zero numerator / divide by zero
      send_fraction_op(op, 32'd3, 32'd0, 32'd1, 32'd2);   // zero denominator
      send_fraction_op(op, 32'hFFFF_FFFA, 32'd4, 32'd9, 32'hFFFF_FFF4);
      send_fraction_op(op, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    end
    send_fraction_op(CMD_MUL, 32'h8000_0000, 32'd1, 32'd1, 32'd1);  // min numerator fits
    send_fraction_op(CMD_MUL, 32'h8000_0000, 32'd1, 32'hFFFF_FFFF, 32'd1);  // overflow
    send_fraction_op(CMD_ADD, 32'd1, 32'd2, 32'hFFFF_FFFF, 32'd2);  // cancels to zero
  endtask

  task automatic test_random(input int count);
    for (int k = 0; k < count; k++)
      send_fraction_op(2'($urandom_range(3)), random_operand(), random_operand(),
        random_operand(), random_operand());
  endtask

  task automatic test_backpressure();
    -> hold_off_go;
    test_random(6);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (expected_fractions.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  initial begin
    rst = 1'b1;
    in_ch.valid = 1'b0;
    in_ch.cmd = '0;
    in_ch.a_num = '0;
    in_ch.a_den = '0;
    in_ch.b_num = '0;
    in_ch.b_den = '0;
    sender_idle_pct = 0;
    receiver_idle_pct = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    sender_idle_pct = 14;
    receiver_idle_pct = 83;
    test_random(360);
    sender_idle_pct = 83;
    receiver_idle_pct = 14;
    test_random(360);
    sender_idle_pct = 0;
    receiver_idle_pct = 0;
    test_backpressure();
    test_random(360);
    drain();
    if (mismatch_count == 0 && expected_fractions.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
